FILE: design/selt_pkg.sv
// Shared types, codes and defaults for the shared/exclusive lock table.
// Used by the lock cell, the top level and the port checker.
package selt_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int KEY_W = 64;
	localparam int OWNER_W = 32;
	localparam int REFS_W = 32;
	localparam int LIM_W = 7;
	localparam int OUT_CNT_W = 7;
	localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_REL_OWNER = 2'd2;
	localparam logic [1:0] OP_CNT_OWNER = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ERROR = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_BUSY = 3'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic               excl;
		logic [KEY_W-1:0]   key;
		logic [OWNER_W-1:0] owner;
	} req_t;

	typedef struct packed {
		logic vld;
		logic own_found;
		logic sat;
		logic busy;
		logic free_found;
	} tok_t;

	typedef struct packed {
		logic inc;
		logic claim;
		logic rel;
		logic clr;
	} cmd_t;

endpackage

FILE: design/selt_cell.sv
// One lock table entry with its compare logic and token stage.
// Depends on selt_pkg.
module selt_cell #(
	parameter int IDX = 0,
	parameter int CNT_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [selt_pkg::LIM_W-1:0] lim,
	input  selt_pkg::req_t             req,
	input  selt_pkg::cmd_t             cmd,
	input  selt_pkg::tok_t             tok_in,
	input  logic [CNT_W-1:0]           cnt_in,
	output selt_pkg::tok_t             tok_out,
	output logic [CNT_W-1:0]           cnt_out
);
	import selt_pkg::*;

	localparam logic [31:0] IDX_C = 32'(IDX);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [OWNER_W-1:0] owner_q;
	logic               excl_q;
	logic [REFS_W-1:0]  refs_q;
	logic               sel_own_q;
	logic               sel_free_q;
	tok_t               tok_q;
	logic [CNT_W-1:0]   cnt_q;

	logic act, key_eq, own_eq, own_match, conflict, is_free, owner_hit;
	logic lock_op, acq_op, owner_op;
	tok_t tok_nxt;

	always_comb begin
		act = {{(32-LIM_W){1'b0}}, lim} > IDX_C;
		key_eq = key_q == req.key;
		own_eq = owner_q == req.owner;
		lock_op = req.op == OP_ACQUIRE || req.op == OP_RELEASE;
		acq_op = req.op == OP_ACQUIRE;
		owner_op = req.op == OP_REL_OWNER || req.op == OP_CNT_OWNER;
		own_match = act && valid_q && key_eq && own_eq && excl_q == req.excl && lock_op;
		conflict = act && valid_q && key_eq && !own_eq && (req.excl || excl_q) && acq_op;
		is_free = act && !valid_q && acq_op;
		owner_hit = act && valid_q && own_eq && owner_op;
		tok_nxt = tok_in;
		if (own_match && !tok_in.own_found) begin
			tok_nxt.own_found = 1'b1;
			tok_nxt.sat = refs_q == '1;
		end
		if (is_free)
			tok_nxt.free_found = 1'b1;
		if (conflict)
			tok_nxt.busy = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
			if (cmd.claim && sel_free_q)
				valid_q <= 1'b1;
			if (cmd.rel && sel_own_q && refs_q <= 32'd1)
				valid_q <= 1'b0;
			if (cmd.clr && owner_hit)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			sel_own_q <= own_match && !tok_in.own_found;
			sel_free_q <= is_free && !tok_in.free_found;
			cnt_q <= cnt_in + CNT_W'(owner_hit);
		end
		if (cmd.inc && sel_own_q)
			refs_q <= refs_q + 32'd1;
		if (cmd.rel && sel_own_q && refs_q > 32'd1)
			refs_q <= refs_q - 32'd1;
		if (cmd.claim && sel_free_q) begin
			key_q <= req.key;
			owner_q <= req.owner;
			excl_q <= req.excl;
			refs_q <= 32'd1;
		end
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

FILE: design/shared_exclusive_lock_table.sv
// Top level of the shared/exclusive lock table: request control and cell chain.
// Depends on selt_pkg and selt_cell.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. Fields: operation, lock_mode, lock_key, lock_owner.
//   Result channel: done is high for one cycle with status and
//   entry_count_out; the receiver cannot stall it.
//   Configuration: cfg_wr_en with cfg_wr_data writes entries_in_use; write
//   only while busy is low and no result is pending.
//   Flow: a request with a zero owner, or a zero key on acquire or
//   release, answers in the cycle after the transfer. Every other request
//   walks a token through the TABLE_ENTRIES cells, one cell per cycle,
//   then commits and shows the result. busy falls with done, so the next
//   item can transfer in the cycle that shows the result.
//   Reset: all entries free, entries_in_use = 64, no result pending.
module shared_exclusive_lock_table #(
	parameter int TABLE_ENTRIES = selt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     operation,
	input  logic                           lock_mode,
	input  logic [selt_pkg::KEY_W-1:0]     lock_key,
	input  logic [selt_pkg::OWNER_W-1:0]   lock_owner,
	input  logic                           cfg_wr_en,
	input  logic [selt_pkg::LIM_W-1:0]     cfg_wr_data,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [selt_pkg::OUT_CNT_W-1:0] entry_count_out
);
	import selt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                 state_q;
	logic [LIM_W-1:0]     lim_q;
	req_t                 req_q;
	tok_t                 launch_q;
	cmd_t                 cmd;
	logic                 done_q;
	logic [2:0]           status_q;
	logic [OUT_CNT_W-1:0] cnt_out_q;
	logic                 accept, bad_req;
	logic [2:0]           status_nxt;
	logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

	tok_t             tok [0:TABLE_ENTRIES];
	logic [CNT_W-1:0] cnt [0:TABLE_ENTRIES];

	assign tok[0] = launch_q;
	assign cnt[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		selt_cell #(
			.IDX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.lim(lim_q),
			.req(req_q),
			.cmd(cmd),
			.tok_in(tok[i]),
			.cnt_in(cnt[i]),
			.tok_out(tok[i+1]),
			.cnt_out(cnt[i+1])
		);
	end

	tok_t last;
	assign last = tok[TABLE_ENTRIES];

	always_comb begin
		accept = start && state_q == S_IDLE;
		bad_req = lock_owner == '0 ||
			((operation == OP_ACQUIRE || operation == OP_RELEASE) && lock_key == '0);
		cmd = '0;
		status_nxt = ST_OK;
		cnt_wide = {{OUT_CNT_W{1'b0}}, cnt[TABLE_ENTRIES]};
		case (req_q.op)
			OP_ACQUIRE: begin
				if (last.own_found) begin
					status_nxt = last.sat ? ST_ERROR : ST_OK;
					cmd.inc = !last.sat;
				end else if (last.busy) begin
					status_nxt = ST_BUSY;
				end else if (last.free_found) begin
					cmd.claim = 1'b1;
				end else begin
					status_nxt = ST_FULL;
				end
			end
			OP_RELEASE: begin
				if (last.own_found)
					cmd.rel = 1'b1;
				else
					status_nxt = ST_NOT_FOUND;
			end
			OP_REL_OWNER: cmd.clr = 1'b1;
			default: ;
		endcase
		if (!(state_q == S_SCAN && last.vld))
			cmd = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lim_q <= LIM_RESET;
			launch_q <= '0;
			done_q <= 1'b0;
		end else begin
			launch_q <= '0;
			done_q <= 1'b0;
			if (cfg_wr_en)
				lim_q <= cfg_wr_data;
			case (state_q)
				S_IDLE: begin
					if (accept && bad_req) begin
						done_q <= 1'b1;
					end else if (accept) begin
						launch_q.vld <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last.vld) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{op: operation, excl: lock_mode, key: lock_key, owner: lock_owner};
			status_q <= ST_ERROR;
			cnt_out_q <= '0;
		end
		if (state_q == S_SCAN && last.vld) begin
			status_q <= status_nxt;
			cnt_out_q <= (req_q.op == OP_REL_OWNER || req_q.op == OP_CNT_OWNER) ?
				cnt_wide[OUT_CNT_W-1:0] : '0;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign entry_count_out = cnt_out_q;

endmodule

FILE: design/selt_chk.sv
// Port checker for the lock table, bound to the top level.
// Depends on selt_pkg and shared_exclusive_lock_table.
module selt_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [2:0]                     status,
	input logic [selt_pkg::OUT_CNT_W-1:0] entry_count_out
);
	import selt_pkg::*;

	a_quiet_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done) else $error("result without transfer");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("transfer left no trace");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_OK || status == ST_ERROR || status == ST_FULL ||
			status == ST_NOT_FOUND || status == ST_BUSY)
		else $error("bad status code");

	a_count_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> entry_count_out == '0)
		else $error("count on failed request");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

endmodule

bind shared_exclusive_lock_table selt_chk u_selt_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.entry_count_out(entry_count_out)
);
